// ----- hw/rtl/srp_pkg.sv -----
`default_nettype none

package srp_pkg;

  localparam int DIM_W   = 16;
  localparam int PAD_W   = 8;
  localparam int COORD_W = 17;
  // working width for unmasked sums of a coordinate, a size and padding
  localparam int CALC_W  = 19;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIMENSION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_PIXELS    = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] MAX_DIMENSION_RST = DIM_W'(2048);
  localparam logic [PAD_W-1:0] PAD_PIXELS_RST    = PAD_W'(1);

  typedef enum logic [1:0] {
    ITEM_PLACED   = 2'd0,
    ITEM_EMPTY    = 2'd1,
    ITEM_OVERSIZE = 2'd2,
    ITEM_FAILED   = 2'd3
  } item_status_t;

  typedef enum logic [1:0] {
    BATCH_NOT_FINAL   = 2'd0,
    BATCH_SHEET_READY = 2'd1,
    BATCH_NO_RECTS    = 2'd2,
    BATCH_NO_FIT      = 2'd3
  } batch_status_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [DIM_W-1:0]   row_tallest;
    logic [COORD_W-1:0] extent_x;
    logic [COORD_W-1:0] extent_y;
    logic               pack_failed;
    logic               any_placed;
  } srp_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] place_x;
    logic [COORD_W-1:0] place_y;
    item_status_t       item_status;
    batch_status_t      batch_status;
    logic [COORD_W-1:0] sheet_width;
    logic [COORD_W-1:0] sheet_height;
    logic               result_last;
  } srp_result_t;

  // state of an empty batch, cursors at the padding
  function automatic srp_state_t empty_state(input logic [PAD_W-1:0] pad);
    srp_state_t s;
    s          = '0;
    s.cursor_x = COORD_W'(pad);
    s.cursor_y = COORD_W'(pad);
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/srp_place_core.sv -----
`default_nettype none

module srp_place_core (
  input  wire srp_pkg::srp_state_t       st,
  input  wire logic [srp_pkg::DIM_W-1:0] rect_width,
  input  wire logic [srp_pkg::DIM_W-1:0] rect_height,
  input  wire logic                      batch_end,
  input  wire logic [srp_pkg::DIM_W-1:0] max_dimension,
  input  wire logic [srp_pkg::PAD_W-1:0] pad_pixels,
  output srp_pkg::srp_state_t            st_nxt,
  output srp_pkg::srp_result_t           res
);
  import srp_pkg::*;

  logic [CALC_W-1:0] w19, h19, pad19, maxd19, rt19, curx19, cury19;
  logic [CALC_W-1:0] x_end_cur, cy_wrap, bottom_end;
  logic [CALC_W-1:0] cx_sel, cy_sel, cx_end, cy_end;
  logic [DIM_W-1:0]  rt_sel, rt_new;
  logic              is_empty, is_over, wrap, bottom_fail, tried, place_ok, fail_now;
  srp_state_t        upd;

  // zero-extend everything to the working width
  assign w19    = CALC_W'(rect_width);
  assign h19    = CALC_W'(rect_height);
  assign pad19  = CALC_W'(pad_pixels);
  assign maxd19 = CALC_W'(max_dimension);
  assign rt19   = CALC_W'(st.row_tallest);
  assign curx19 = CALC_W'(st.cursor_x);
  assign cury19 = CALC_W'(st.cursor_y);

  // rejection checks
  assign is_empty = (rect_width == '0) || (rect_height == '0);
  assign is_over  = (rect_width > max_dimension) || (rect_height > max_dimension);
  assign tried    = !is_empty && !is_over && !st.pack_failed;

  // right edge check, row change and bottom edge check
  assign x_end_cur   = curx19 + w19 + pad19;
  assign wrap        = x_end_cur > maxd19;
  assign cy_wrap     = cury19 + rt19 + pad19;
  assign bottom_end  = cy_wrap + h19 + pad19;
  assign bottom_fail = bottom_end > maxd19;

  assign place_ok = tried && !(wrap && bottom_fail);
  assign fail_now = tried && wrap && bottom_fail;

  // position on the chosen row
  assign cx_sel = wrap ? pad19 : curx19;
  assign cy_sel = wrap ? cy_wrap : cury19;
  assign rt_sel = wrap ? '0 : st.row_tallest;
  assign cx_end = cx_sel + w19 + pad19;
  assign cy_end = cy_sel + h19;
  assign rt_new = (rect_height > rt_sel) ? rect_height : rt_sel;

  // state after this rectangle
  always_comb begin
    upd = st;
    if (fail_now) begin
      upd.pack_failed = 1'b1;
    end
    if (place_ok) begin
      upd.cursor_x    = cx_end[COORD_W-1:0];
      upd.cursor_y    = cy_sel[COORD_W-1:0];
      upd.row_tallest = rt_new;
      if (cx_end > CALC_W'(st.extent_x)) begin
        upd.extent_x = cx_end[COORD_W-1:0];
      end
      if (cy_end > CALC_W'(st.extent_y)) begin
        upd.extent_y = cy_end[COORD_W-1:0];
      end
      upd.any_placed = 1'b1;
    end
  end

  // result fields and end of batch clear
  always_comb begin
    res              = '0;
    res.result_last  = batch_end;
    res.batch_status = BATCH_NOT_FINAL;
    if (place_ok) begin
      res.place_x = cx_sel[COORD_W-1:0];
      res.place_y = cy_sel[COORD_W-1:0];
    end
    priority if (is_empty) begin
      res.item_status = ITEM_EMPTY;
    end else if (is_over) begin
      res.item_status = ITEM_OVERSIZE;
    end else if (!place_ok) begin
      res.item_status = ITEM_FAILED;
    end else begin
      res.item_status = ITEM_PLACED;
    end

    st_nxt = upd;
    if (batch_end) begin
      priority if (upd.pack_failed) begin
        res.batch_status = BATCH_NO_FIT;
      end else if (!upd.any_placed) begin
        res.batch_status = BATCH_NO_RECTS;
      end else begin
        res.batch_status = BATCH_SHEET_READY;
        res.sheet_width  = upd.extent_x + COORD_W'(pad_pixels);
        res.sheet_height = upd.extent_y + COORD_W'(pad_pixels);
      end
      st_nxt             = '0;
      st_nxt.cursor_x    = COORD_W'(pad_pixels);
      st_nxt.cursor_y    = COORD_W'(pad_pixels);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/shelf_rect_packer.sv -----
// path: the rectangle passes through the input register, then the placement logic
// into the result register
// throughput: one rectangle per cycle while out_ready allows, set by the cursor update loop;
// a pending register write holds off input until the pipeline is empty
// reset (rst_n low, synchronous): pipeline empties, max_dimension 2048,
// pad_pixels 1, cursors at the padding, extents and flags cleared
`default_nettype none

module shelf_rect_packer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [srp_pkg::DIM_W-1:0]      in_rect_width,
  input  wire logic [srp_pkg::DIM_W-1:0]      in_rect_height,
  input  wire logic                           in_batch_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [srp_pkg::COORD_W-1:0]         out_place_x,
  output logic [srp_pkg::COORD_W-1:0]         out_place_y,
  output logic [1:0]                          out_item_status,
  output logic [1:0]                          out_batch_status,
  output logic [srp_pkg::COORD_W-1:0]         out_sheet_width,
  output logic [srp_pkg::COORD_W-1:0]         out_sheet_height,
  output logic                                out_result_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srp_pkg::*;

  logic               in_valid_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic               last_r;
  logic               out_valid_r;
  srp_result_t        res_r, res_nxt;
  srp_state_t         st_r, st_nxt;
  logic [DIM_W-1:0]   max_dim_r;
  logic [PAD_W-1:0]   pad_r;
  logic               advance, fire, cfg_fire;

  // pipeline control, a register write waits for an empty pipeline
  assign advance   = !out_valid_r || out_ready;
  assign fire      = in_valid_r && advance;
  assign in_ready  = (!in_valid_r || advance) && !cfg_valid;
  assign cfg_ready = !in_valid_r && !out_valid_r;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      width_r  <= in_rect_width;
      height_r <= in_rect_height;
      last_r   <= in_batch_end;
    end
  end

  // placement logic
  srp_place_core u_core (
    .st            (st_r),
    .rect_width    (width_r),
    .rect_height   (height_r),
    .batch_end     (last_r),
    .max_dimension (max_dim_r),
    .pad_pixels    (pad_r),
    .st_nxt        (st_nxt),
    .res           (res_nxt)
  );

  // configuration registers and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= MAX_DIMENSION_RST;
      pad_r     <= PAD_PIXELS_RST;
      st_r      <= empty_state(PAD_PIXELS_RST);
    end else if (fire) begin
      st_r <= st_nxt;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_MAX_DIMENSION) begin
        max_dim_r <= cfg_data[DIM_W-1:0];
      end else if (cfg_index == CFG_PAD_PIXELS) begin
        pad_r <= cfg_data[PAD_W-1:0];
        // an empty batch holds nothing but the cursors
        if (!st_r.any_placed && !st_r.pack_failed) begin
          st_r <= empty_state(cfg_data[PAD_W-1:0]);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_place_x      = res_r.place_x;
  assign out_place_y      = res_r.place_y;
  assign out_item_status  = res_r.item_status;
  assign out_batch_status = res_r.batch_status;
  assign out_sheet_width  = res_r.sheet_width;
  assign out_sheet_height = res_r.sheet_height;
  assign out_result_last  = res_r.result_last;

`ifndef SYNTHESIS
  // a batch end leaves a clean batch behind
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last_r |=> !st_r.any_placed && !st_r.pack_failed &&
      st_r.extent_x == '0 && st_r.extent_y == '0)
    else $error("state not cleared after batch end");

  // only the final result carries a batch status
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.result_last == (res_r.batch_status != BATCH_NOT_FINAL)))
    else $error("batch status does not match result_last");

  // a placed rectangle mid-batch marks the batch as used
  a_placed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !last_r && res_nxt.item_status == ITEM_PLACED |=> st_r.any_placed)
    else $error("placement not recorded");

  // a failed batch places nothing further
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire && st_r.pack_failed |-> res_nxt.item_status != ITEM_PLACED)
    else $error("placement after batch failure");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(8'hFF);

  logic clk = 1'b0;
  logic rst_n;

  logic in_valid;
  logic in_ready;
  logic [DIM_W-1:0] in_rect_width;
  logic [DIM_W-1:0] in_rect_height;
  logic in_batch_end;
  logic out_valid;
  logic out_ready;
  logic [COORD_W-1:0] out_place_x;
  logic [COORD_W-1:0] out_place_y;
  logic [1:0] out_item_status;
  logic [1:0] out_batch_status;
  logic [COORD_W-1:0] out_sheet_width;
  logic [COORD_W-1:0] out_sheet_height;
  logic out_result_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the packer registers and shelf state
  logic [DIM_W-1:0]   sheet_max_dim;
  logic [PAD_W-1:0]   sheet_pad;
  logic [COORD_W-1:0] shelf_x;
  logic [COORD_W-1:0] shelf_y;
  logic [DIM_W-1:0]   shelf_tallest;
  logic [COORD_W-1:0] used_w;
  logic [COORD_W-1:0] used_h;
  logic               batch_failed;
  logic               batch_has_rect;

  // expected placements in acceptance order
  srp_result_t placement_q[$];
  srp_result_t next_placement;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap_max = 10;
  int unsigned rx_stall_max = 10;
  int unsigned rx_hold_cycles = 0;

  shelf_rect_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_batch_end     (in_batch_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_place_x      (out_place_x),
    .out_place_y      (out_place_y),
    .out_item_status  (out_item_status),
    .out_batch_status (out_batch_status),
    .out_sheet_width  (out_sheet_width),
    .out_sheet_height (out_sheet_height),
    .out_result_last  (out_result_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // shelf state back to an empty sheet
  function automatic void clear_shelf();
    shelf_x = COORD_W'(sheet_pad);
    shelf_y = COORD_W'(sheet_pad);
    shelf_tallest = '0;
    used_w = '0;
    used_h = '0;
    batch_failed = 1'b0;
    batch_has_rect = 1'b0;
  endfunction

  // next-fit shelf placement of one rectangle, returns the expected result
  function automatic srp_result_t place_rect(input logic [DIM_W-1:0] w,
                                             input logic [DIM_W-1:0] h,
                                             input logic last);
    srp_result_t r;
    int unsigned cx, cy, rt, pad, maxd, wi, hi;
    bit fits;
    r = '0;
    r.item_status = ITEM_PLACED;
    r.batch_status = BATCH_NOT_FINAL;
    pad = 32'(sheet_pad);
    maxd = 32'(sheet_max_dim);
    wi = 32'(w);
    hi = 32'(h);
    if (wi == 0 || hi == 0) begin
      r.item_status = ITEM_EMPTY;
    end else if (wi > maxd || hi > maxd) begin
      r.item_status = ITEM_OVERSIZE;
    end else if (batch_failed) begin
      r.item_status = ITEM_FAILED;
    end else begin
      cx = 32'(shelf_x);
      cy = 32'(shelf_y);
      rt = 32'(shelf_tallest);
      fits = 1'b1;
      // no room before the right edge: open a new shelf
      if (cx + wi + pad > maxd) begin
        cx = pad;
        cy = cy + rt + pad;
        rt = 0;
        fits = (cy + hi + pad <= maxd);
      end
      if (!fits) begin
        batch_failed = 1'b1;
        r.item_status = ITEM_FAILED;
      end else begin
        r.place_x = COORD_W'(cx);
        r.place_y = COORD_W'(cy);
        cx = cx + wi + pad;
        if (hi > rt) rt = hi;
        if (cx > 32'(used_w)) used_w = COORD_W'(cx);
        if (cy + hi > 32'(used_h)) used_h = COORD_W'(cy + hi);
        shelf_x = COORD_W'(cx);
        shelf_y = COORD_W'(cy);
        shelf_tallest = DIM_W'(rt);
        batch_has_rect = 1'b1;
      end
    end
    // batch close: failure wins over empty, empty over a ready sheet
    if (last) begin
      if (batch_failed) begin
        r.batch_status = BATCH_NO_FIT;
      end else if (!batch_has_rect) begin
        r.batch_status = BATCH_NO_RECTS;
      end else begin
        r.batch_status = BATCH_SHEET_READY;
        r.sheet_width = COORD_W'(used_w + COORD_W'(sheet_pad));
        r.sheet_height = COORD_W'(used_h + COORD_W'(sheet_pad));
      end
      clear_shelf();
    end
    r.result_last = last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // one rectangle transaction on the input channel
  task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rect_width <= w;
    in_rect_height <= h;
    in_batch_end <= last;
    do @(posedge clk); while (!in_ready);
    placement_q.push_back(place_rect(w, h, last));
  endtask

  // register write; more keeps valid high for a write that follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_DIMENSION: sheet_max_dim = data;
      CFG_PAD_PIXELS: begin
        sheet_pad = data[PAD_W-1:0];
        if (!batch_has_rect && !batch_failed) begin
          shelf_x = COORD_W'(sheet_pad);
          shelf_y = COORD_W'(sheet_pad);
        end
      end
      default: ;
    endcase
  endtask

  // stop offering and let every expected result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // side length biased toward edges, rejects and a few per shelf
  function automatic logic [DIM_W-1:0] pick_side(input int unsigned maxd);
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    top = (maxd / 4 > 1) ? maxd / 4 : 1;
    if (roll < 4) return '0;
    if (roll < 8) return '1;
    if (roll < 12) return (maxd < 65535) ? DIM_W'($urandom_range(maxd + 1, 65535)) : '1;
    if (roll < 16) return DIM_W'(maxd);
    if (roll < 20) return DIM_W'($urandom());
    return DIM_W'($urandom_range(1, top));
  endfunction

  // well-formed batches with random content
  task automatic run_batches(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 24);
      for (int unsigned i = 0; i < len; i++)
        send_rect(pick_side(32'(sheet_max_dim)), pick_side(32'(sheet_max_dim)),
                  i == len - 1);
      sent += len;
    end
  endtask

  // reset values, rejects, shelf change, bottom-edge failure, sheet ready
  task automatic test_rejects_and_failure();
    send_rect(16'd0, 16'd5, 1'b0);
    send_rect(16'd5, 16'd0, 1'b0);
    send_rect(16'd2049, 16'd1, 1'b0);
    send_rect(16'd1, 16'hFFFF, 1'b0);
    send_rect(16'd0, 16'd0, 1'b1);
    send_rect(16'd2046, 16'd10, 1'b0);
    send_rect(16'd1, 16'd1, 1'b0);
    send_rect(16'd2048, 16'd2035, 1'b0);
    send_rect(16'd5, 16'd5, 1'b0);
    send_rect(16'd0, 16'd5, 1'b1);
    send_rect(16'd10, 16'd20, 1'b0);
    send_rect(16'd30, 16'd5, 1'b1);
  endtask

  // padding reload on empty batch, padding change mid-batch, extreme limits
  task automatic test_register_edges();
    wait_drained();
    write_reg(CFG_PAD_PIXELS, 16'hAB07, 1'b0);
    send_rect(16'd3, 16'd3, 1'b0);
    wait_drained();
    write_reg(CFG_PAD_PIXELS, 16'h0000, 1'b0);
    send_rect(16'd3, 16'd3, 1'b1);
    wait_drained();
    write_reg(CFG_MAX_DIMENSION, 16'h0000, 1'b1);
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF, 1'b0);
    send_rect(16'd1, 16'd1, 1'b1);
    wait_drained();
    write_reg(CFG_MAX_DIMENSION, 16'hFFFF, 1'b1);
    write_reg(CFG_PAD_PIXELS, 16'h00FF, 1'b0);
    send_rect(16'hFFFF, 16'hFFFF, 1'b0);
    send_rect(16'd1, 16'd1, 1'b1);
    wait_drained();
    write_reg(CFG_MAX_DIMENSION, 16'd1, 1'b1);
    write_reg(CFG_PAD_PIXELS, 16'd0, 1'b0);
    send_rect(16'd1, 16'd1, 1'b0);
    send_rect(16'd1, 16'd1, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    wait_drained();
    write_reg(CFG_MAX_DIMENSION, 16'd512, 1'b1);
    write_reg(CFG_PAD_PIXELS, 16'd2, 1'b0);
    tx_gap_max = 0;
    rx_hold_cycles = 300;
    run_batches(40);
    wait_drained();
    tx_gap_max = 10;
  endtask

  // several register settings, extremes first, with and without idling
  task automatic test_random_batches();
    logic [CFG_DATA_W-1:0] dims[8];
    logic [CFG_DATA_W-1:0] pads[8];
    dims = '{16'd2048, 16'd64, 16'hFFFF, 16'd300, 16'd1, 16'hFFFF, 16'd0, 16'd0};
    pads = '{16'd1, 16'd3, 16'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    dims[6] = CFG_DATA_W'($urandom_range(1, 65535));
    dims[7] = CFG_DATA_W'($urandom_range(1, 4096));
    pads[6] = CFG_DATA_W'($urandom_range(0, 255));
    pads[7] = CFG_DATA_W'($urandom_range(0, 16));
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_reg(CFG_MAX_DIMENSION, dims[p], 1'b1);
      write_reg(CFG_PAD_PIXELS, pads[p], 1'b0);
      tx_gap_max = (p % 3 == 0) ? 0 : 10;
      rx_stall_max = (p % 3 == 1) ? 0 : 10;
      run_batches(182);
    end
  endtask

  // receiver: random stall per transaction, long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned hold;
    forever begin
      if (rx_hold_cycles != 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && rx_hold_cycles == 0);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        next_placement = placement_q.pop_front();
        check_field("place_x", out_place_x, next_placement.place_x);
        check_field("place_y", out_place_y, next_placement.place_y);
        check_field("item_status", COORD_W'(out_item_status),
                    COORD_W'(next_placement.item_status));
        check_field("batch_status", COORD_W'(out_batch_status),
                    COORD_W'(next_placement.batch_status));
        check_field("sheet_width", out_sheet_width, next_placement.sheet_width);
        check_field("sheet_height", out_sheet_height, next_placement.sheet_height);
        check_field("result_last", COORD_W'(out_result_last),
                    COORD_W'(next_placement.result_last));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rect_width <= '0;
    in_rect_height <= '0;
    in_batch_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    sheet_max_dim = MAX_DIMENSION_RST;
    sheet_pad = PAD_PIXELS_RST;
    clear_shelf();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_rejects_and_failure();
    test_register_edges();
    test_backpressure();
    test_random_batches();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/srp_pkg.sv
hw/rtl/srp_place_core.sv
hw/rtl/shelf_rect_packer.sv
tb/tb.sv
